[rtl/per_host_priority_slot_limiter_macros.svh]
// Assertion macros shared by the checker
`ifndef PER_HOST_PRIORITY_SLOT_LIMITER_MACROS_SVH
`define PER_HOST_PRIORITY_SLOT_LIMITER_MACROS_SVH
// assert that a implies b on the next clock
`define PHL_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("%s failed", "label");
// assert a combinational condition each clock
`define PHL_ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("%s failed", "label");
`endif

[rtl/phl_pkg.sv]
// ----------------------------------------------------------------------------
// phl_pkg
// Status codes, reset max_active value and command code of the per-host slot limiter.
// ----------------------------------------------------------------------------
`default_nettype none
package phl_pkg;
    localparam logic [2:0] ST_GRANTED = 3'd0;
    localparam logic [2:0] ST_QUEUED  = 3'd1;
    localparam logic [2:0] ST_HANDED  = 3'd2;
    localparam logic [2:0] ST_FREED   = 3'd3;
    localparam logic [2:0] ST_IGNORED = 3'd4;
    localparam logic [2:0] ST_FULL    = 3'd5;
    localparam logic [3:0] MAX_ACTIVE_RESET = 4'd6;
    localparam logic       CMD_ACQUIRE = 1'b0;
endpackage
`default_nettype wire

[rtl/phl_ram.sv]
// ----------------------------------------------------------------------------
// phl_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module phl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[rtl/per_host_priority_slot_limiter.sv]
// ----------------------------------------------------------------------------
// per_host_priority_slot_limiter
// Per-host counting semaphore with a shared priority waiting table.
// ----------------------------------------------------------------------------
// Each transaction takes its result from one pass through the state RAMs. An
// acquire, or a release that finds a zero count, passes through S_RDCNT and
// S_DEC to S_OUT, where its result waits for m_ready. Any other release walks
// the waiting-table RAM one entry a cycle in S_SCAN, then passes through
// S_DONE to S_OUT. Only one transaction is in the block at a time, and a
// result held off by m_ready stalls the input. Active counts live in one RAM
// of HOSTS entries, waiter records in one RAM of WAIT_SLOTS entries; a
// clearing pass over all HOSTS entries after reset zeroes the count RAM before
// the first transaction is accepted.
`default_nettype none
module per_host_priority_slot_limiter
    import phl_pkg::*;
#(
    parameter int HOSTS      = 16,
    parameter int WAIT_SLOTS = 32
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_we,
    input  wire logic [3:0] cfg_wdata,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_command,
    input  wire logic [3:0] s_host_index,
    input  wire logic [1:0] s_priority_req,
    input  wire logic [7:0] s_request_tag,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [2:0]      m_status,
    output logic [7:0]      m_woken_tag,
    output logic [3:0]      m_active_after
);
    localparam int HW = (HOSTS > 1) ? $clog2(HOSTS) : 1;
    localparam int WW = $clog2(WAIT_SLOTS);
    localparam int RW = 4 + 2 + 64 + 8;   // host, priority, order, tag

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RDCNT = 3'd2;
    localparam logic [2:0] S_DEC   = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    // host index wrapped into range, as a small constant table
    function automatic logic [3:0] host_wrap(input logic [3:0] h);
        logic [3:0] r;
        r = '0;
        for (int i = 0; i < 16; i++) begin
            if (h == 4'(i)) r = 4'(i % HOSTS);
        end
        return r;
    endfunction

    logic [2:0]      state_reg, state_next;
    logic [3:0]      max_reg;
    logic [HW-1:0]   clr_reg;
    logic            cmd_reg;
    logic [HW-1:0]   host_reg;
    logic [3:0]      host_raw_reg;
    logic [1:0]      prio_reg;
    logic [7:0]      tag_reg;
    logic [3:0]      cnt_reg;
    logic [WAIT_SLOTS-1:0] valid_reg;
    logic [WW:0]     scan_reg;      // address issued
    logic            rd_ok_reg;     // RAM data valid for entry scan_reg-1
    logic [WW-1:0]   rd_idx_reg;
    logic            found_reg;
    logic [WW-1:0]   best_reg;
    logic [1:0]      best_prio_reg;
    logic [63:0]     best_order_reg;
    logic [7:0]      best_tag_reg;
    logic [63:0]     arrival_reg;

    // count RAM
    logic            c_we;
    logic [HW-1:0]   c_waddr;
    logic [3:0]      c_wdata, c_rdata;
    phl_ram #(.WIDTH(4), .DEPTH(HOSTS)) u_cnt (
        .aclk(aclk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
        .raddr(host_reg), .rdata(c_rdata));

    // waiter RAM
    logic            w_we;
    logic [WW-1:0]   w_waddr;
    logic [RW-1:0]   w_rdata;
    logic [WW-1:0]   free_idx;
    logic            free_ok;
    phl_ram #(.WIDTH(RW), .DEPTH(WAIT_SLOTS)) u_wait (
        .aclk(aclk), .we(w_we), .waddr(w_waddr),
        .wdata({host_raw_reg, prio_reg, arrival_reg, tag_reg}),
        .raddr(scan_reg[WW-1:0]), .rdata(w_rdata));

    // lowest free entry, priority encoder over valid flops
    always_comb begin
        free_ok  = 1'b0;
        free_idx = '0;
        for (int i = WAIT_SLOTS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_ok  = 1'b1;
                free_idx = WW'(i);
            end
        end
    end

    logic [3:0]  e_host;
    logic [1:0]  e_prio;
    logic [63:0] e_order;
    logic [7:0]  e_tag;
    logic        e_better;
    assign {e_host, e_prio, e_order, e_tag} = w_rdata;
    assign e_better = rd_ok_reg && valid_reg[rd_idx_reg] && e_host == host_raw_reg &&
        (!found_reg || e_prio < best_prio_reg ||
         (e_prio == best_prio_reg && e_order < best_order_reg));

    // count RAM data is valid during S_DEC
    logic grant;
    assign grant = c_rdata < max_reg;

    assign s_ready = state_reg == S_IDLE;

    always_comb begin
        state_next = state_reg;
        c_we = 1'b0; c_waddr = host_reg; c_wdata = cnt_reg;
        w_we = 1'b0; w_waddr = free_idx;
        case (state_reg)
            S_CLEAR: begin
                c_we = 1'b1; c_waddr = clr_reg; c_wdata = '0;
                if (clr_reg == HW'(HOSTS - 1)) state_next = S_IDLE;
            end
            S_IDLE:  if (s_valid) state_next = S_RDCNT;
            S_RDCNT: state_next = S_DEC;
            S_DEC: begin
                if (cmd_reg == CMD_ACQUIRE) begin
                    if (grant) begin
                        c_we = 1'b1; c_wdata = c_rdata + 4'd1;
                        state_next = S_OUT;
                    end else begin
                        if (free_ok) w_we = 1'b1;
                        state_next = S_OUT;
                    end
                end else if (c_rdata == 4'd0) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: if (scan_reg == (WW+1)'(WAIT_SLOTS) && rd_ok_reg) state_next = S_DONE;
            S_DONE: begin
                if (!found_reg) begin
                    c_we = 1'b1; c_wdata = cnt_reg - 4'd1;
                end
                state_next = S_OUT;
            end
            S_OUT:   if (m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            max_reg     <= MAX_ACTIVE_RESET;
            clr_reg     <= '0;
            valid_reg   <= '0;
            arrival_reg <= '0;
            m_valid     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) max_reg <= cfg_wdata;
            if (state_reg == S_CLEAR) clr_reg <= clr_reg + HW'(1);
            case (state_reg)
                S_IDLE: if (s_valid) begin
                    cmd_reg      <= s_command;
                    host_reg     <= HW'(host_wrap(s_host_index));
                    host_raw_reg <= host_wrap(s_host_index);
                    prio_reg     <= s_priority_req;
                    tag_reg      <= s_request_tag;
                end
                S_RDCNT: ;
                S_DEC: begin
                    cnt_reg   <= c_rdata;
                    scan_reg  <= '0;
                    rd_ok_reg <= 1'b0;
                    found_reg <= 1'b0;
                end
                S_SCAN: begin
                    if (scan_reg != (WW+1)'(WAIT_SLOTS)) scan_reg <= scan_reg + (WW+1)'(1);
                    rd_ok_reg  <= scan_reg != (WW+1)'(WAIT_SLOTS);
                    rd_idx_reg <= scan_reg[WW-1:0];
                    if (e_better) begin
                        found_reg      <= 1'b1;
                        best_reg       <= rd_idx_reg;
                        best_prio_reg  <= e_prio;
                        best_order_reg <= e_order;
                        best_tag_reg   <= e_tag;
                    end
                end
                default: ;
            endcase
            // result and state update
            if (state_reg == S_DEC) begin
                m_woken_tag <= '0;
                if (cmd_reg == CMD_ACQUIRE) begin
                    if (grant) begin
                        m_status <= ST_GRANTED; m_active_after <= c_rdata + 4'd1;
                    end else if (free_ok) begin
                        m_status <= ST_QUEUED; m_active_after <= c_rdata;
                        valid_reg[free_idx] <= 1'b1;
                        arrival_reg <= arrival_reg + 64'd1;
                    end else begin
                        m_status <= ST_FULL; m_active_after <= c_rdata;
                    end
                    m_valid <= 1'b1;
                end else if (c_rdata == 4'd0) begin
                    m_status <= ST_IGNORED; m_active_after <= '0;
                    m_valid <= 1'b1;
                end
            end
            if (state_reg == S_DONE) begin
                if (found_reg) begin
                    valid_reg[best_reg] <= 1'b0;
                    m_status <= ST_HANDED; m_woken_tag <= best_tag_reg;
                    m_active_after <= cnt_reg;
                end else begin
                    m_status <= ST_FREED; m_woken_tag <= '0;
                    m_active_after <= cnt_reg - 4'd1;
                end
                m_valid <= 1'b1;
            end
            if (state_reg == S_OUT && m_ready) m_valid <= 1'b0;
        end
    end
endmodule
`default_nettype wire

[rtl/phl_checker.sv]
// ----------------------------------------------------------------------------
// phl_checker
// Port-level checks of the slot limiter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "per_host_priority_slot_limiter_macros.svh"
module phl_checker
    import phl_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [2:0] m_status,
    input wire logic [7:0] m_woken_tag,
    input wire logic [3:0] m_active_after
);
    // one transaction at a time: no new input while a result waits
    `PHL_ASSERT_NOW(a_no_accept_pending, aclk, aresetn, m_valid, !s_ready)
    `PHL_ASSERT_NOW(a_tag_only_handed, aclk, aresetn,
        m_valid && m_status != ST_HANDED, m_woken_tag == 8'd0)
    `PHL_ASSERT_NOW(a_ignored_zero, aclk, aresetn,
        m_valid && m_status == ST_IGNORED, m_active_after == 4'd0)
    `PHL_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_status) && $stable(m_active_after))
endmodule

bind per_host_priority_slot_limiter phl_checker u_phl_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
    .m_woken_tag(m_woken_tag), .m_active_after(m_active_after));
`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Checks the per-host slot limiter against a local model of its slot counts
// and priority waiting table. Directed acquire/release sequences are followed
// by random phases under several max_active settings, with random stalls on
// both channels.
// ----------------------------------------------------------------------------
typedef struct {
    logic [2:0] status;
    logic [7:0] woken_tag;
    logic [3:0] active_after;
} slot_outcome_t;

class slot_ledger;
    logic [3:0]  max_active;
    logic [3:0]  host_count [16];
    bit          entry_used [32];
    logic [3:0]  entry_host [32];
    logic [1:0]  entry_prio [32];
    logic [63:0] entry_seq  [32];
    logic [7:0]  entry_tag  [32];
    logic [63:0] arrival_seq;
    slot_outcome_t expected_outcomes [$];
    int          mismatches;

    function new();
        max_active  = phl_pkg::MAX_ACTIVE_RESET;
        arrival_seq = '0;
        mismatches  = 0;
        for (int i = 0; i < 16; i++) host_count[i] = '0;
        for (int i = 0; i < 32; i++) entry_used[i] = 1'b0;
    endfunction

    task flag_mismatch(string what, logic [7:0] got, logic [7:0] want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function int pending();
        return expected_outcomes.size();
    endfunction

    function void note_request(logic cmd, logic [3:0] h, logic [1:0] prio, logic [7:0] tag);
        slot_outcome_t o;
        int best;
        o.woken_tag = '0;
        best = -1;
        if (cmd == phl_pkg::CMD_ACQUIRE) begin
            if (host_count[h] < max_active) begin
                host_count[h] = host_count[h] + 4'd1;
                o.status = phl_pkg::ST_GRANTED;
            end else begin
                o.status = phl_pkg::ST_FULL;
                for (int i = 0; i < 32; i++) begin
                    if (!entry_used[i]) begin
                        entry_used[i] = 1'b1;
                        entry_host[i] = h;
                        entry_prio[i] = prio;
                        entry_seq[i]  = arrival_seq;
                        entry_tag[i]  = tag;
                        arrival_seq++;
                        o.status = phl_pkg::ST_QUEUED;
                        break;
                    end
                end
            end
        end else if (host_count[h] == 0) begin
            o.status = phl_pkg::ST_IGNORED;
        end else begin
            for (int i = 0; i < 32; i++) begin
                if (entry_used[i] && entry_host[i] == h) begin
                    if (best < 0 || entry_prio[i] < entry_prio[best] ||
                        (entry_prio[i] == entry_prio[best] && entry_seq[i] < entry_seq[best]))
                        best = i;
                end
            end
            if (best >= 0) begin
                entry_used[best] = 1'b0;
                o.status = phl_pkg::ST_HANDED;
                o.woken_tag = entry_tag[best];
            end else begin
                host_count[h] = host_count[h] - 4'd1;
                o.status = phl_pkg::ST_FREED;
            end
        end
        o.active_after = host_count[h];
        expected_outcomes = {expected_outcomes, o};
    endfunction

    task check_outcome(logic [2:0] status, logic [7:0] woken_tag, logic [3:0] active_after);
        slot_outcome_t o;
        if (expected_outcomes.size() == 0) begin
            flag_mismatch("unexpected transaction, status", 8'(status), 8'd0);
        end else begin
            o = expected_outcomes.pop_front();
            if (status !== o.status) flag_mismatch("status", 8'(status), 8'(o.status));
            if (woken_tag !== o.woken_tag) flag_mismatch("woken_tag", woken_tag, o.woken_tag);
            if (active_after !== o.active_after)
                flag_mismatch("active_after", 8'(active_after), 8'(o.active_after));
        end
    endtask
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_we = 1'b0;
    logic [3:0] cfg_wdata = '0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_command = 1'b0;
    logic [3:0] s_host_index = '0;
    logic [1:0] s_priority_req = '0;
    logic [7:0] s_request_tag = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [2:0] m_status;
    logic [7:0] m_woken_tag;
    logic [3:0] m_active_after;

    slot_ledger ledger = new();
    bit send_burst = 1'b0;
    bit recv_burst = 1'b0;
    int hold_off_cycles = 0;

    per_host_priority_slot_limiter i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_host_index  (s_host_index),
        .s_priority_req(s_priority_req),
        .s_request_tag (s_request_tag),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_woken_tag   (m_woken_tag),
        .m_active_after(m_active_after)
    );

    always #10 aclk = ~aclk;

    task send_item(logic cmd, logic [3:0] h, logic [1:0] prio, logic [7:0] tag);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_command      <= cmd;
        s_host_index   <= h;
        s_priority_req <= prio;
        s_request_tag  <= tag;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        ledger.note_request(cmd, h, prio, tag);
    endtask

    // park the sender and let the last transaction finish inside the block
    task drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (ledger.pending() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task set_max_active(logic [3:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        ledger.max_active = v;
    endtask

    task random_phase(logic [3:0] max_v, int acq_pct, int count, bit burst);
        logic [3:0] h;
        set_max_active(max_v);
        send_burst = burst;
        recv_burst = burst;
        for (int n = 0; n < count; n++) begin
            h = ($urandom_range(0, 99) < 70) ? 4'($urandom_range(0, 3))
                                              : 4'($urandom_range(0, 15));
            send_item(($urandom_range(0, 99) < acq_pct) ? 1'b0 : 1'b1, h,
                      2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
        send_burst = 1'b0;
        recv_burst = 1'b0;
    endtask

    initial begin
        int gap;
        forever begin
            if (hold_off_cycles > 0) begin
                gap = hold_off_cycles;
                hold_off_cycles = 0;
            end else begin
                gap = recv_burst ? 0 : $urandom_range(0, 17);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (m_valid !== 1'b1) @(posedge aclk);
            ledger.check_outcome(m_status, m_woken_tag, m_active_after);
        end
    end

    initial begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // release with nothing held, field extremes, plain free
        send_item(1'b1, 4'd0, 2'd0, 8'd0);
        send_item(1'b0, 4'd15, 2'd3, 8'd255);
        send_item(1'b0, 4'd0, 2'd0, 8'd0);
        send_item(1'b1, 4'd15, 2'd3, 8'd255);
        send_item(1'b1, 4'd0, 2'd1, 8'd85);

        // priority first, then arrival order among equal priorities
        set_max_active(4'd1);
        send_item(1'b0, 4'd1, 2'd2, 8'd10);
        send_item(1'b0, 4'd1, 2'd2, 8'd11);
        send_item(1'b0, 4'd1, 2'd0, 8'd12);
        send_item(1'b0, 4'd1, 2'd2, 8'd13);
        send_item(1'b0, 4'd2, 2'd1, 8'd170);
        send_item(1'b1, 4'd1, 2'd3, 8'd0);
        send_item(1'b1, 4'd1, 2'd0, 8'd0);
        send_item(1'b1, 4'd1, 2'd0, 8'd0);
        send_item(1'b1, 4'd1, 2'd0, 8'd0);
        send_item(1'b1, 4'd1, 2'd0, 8'd0);
        send_item(1'b1, 4'd2, 2'd0, 8'd0);

        random_phase(4'd1, 70, 150, 1'b0);
        random_phase(4'd15, 50, 150, 1'b0);
        // zero max: everything waits until the table fills
        random_phase(4'd0, 80, 100, 1'b0);
        // raise max again after counts sat above the zero max, then drain the stuck waiters
        random_phase(4'd15, 40, 200, 1'b0);

        // long receiver stall while the sender keeps pushing
        drain();
        hold_off_cycles = 400;
        random_phase(4'd2, 55, 200, 1'b1);
        random_phase(4'd3, 50, 200, 1'b0);

        drain();
        if (ledger.mismatches == 0 && ledger.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
